@@ design/assert_macros.svh @@
// assertion macros used by the solver core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

@@ design/bts_pkg.sv @@
// package with types and constants of the banded triangular solver
package bts_pkg;
    localparam int DATA_W   = 32;
    localparam int ACC_W    = 64;
    localparam int MAX_SIZE = 16;

    typedef enum logic [1:0] {
        OP_MATRIX = 2'd0,
        OP_RHS    = 2'd1,
        OP_SOLVE  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_SIZE      = 2'd1,
        CFG_BAND      = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_RD,
        S_MUL,
        S_MAC,
        S_DIAG,
        S_DIV,
        S_DIVWAIT,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

@@ design/banded_triangular_solver_core.sv @@
// top level of the banded triangular solver
// usage:
//   s_axis_* carries one transaction per item: write matrix entry, write
//   right-hand-side entry, or start a solve (opcode in tdata bits 1:0).
//   load transactions are taken back to back, one per cycle, and give no result.
//   a solve of n unknowns with band m runs row by row through one shared
//   multiplier and one bit-serial divider: per row a setup step, a read,
//   multiply and accumulate step per off-diagonal term (min(m, terms in the
//   row)), then the diagonal read, divider start, the 64-bit quotient, done
//   and result write, and a step to hand the result over.
//   solve results leave on m_axis_*, one transaction per solved entry in
//   solve order, tlast on the final one; s_axis_tready is low during a solve.
//   a stalled receiver holds the result register; the next row waits before
//   its division until the pending result is taken.
//   config writes (cfg_we, cfg_addr, cfg_wdata) must only be issued while idle.
//   reset is synchronous active low: direction 0, size 16, band 15,
//   stores are not cleared; their entries are undefined until written.
//   matrix store is a single-port memory with registered read data.
module banded_triangular_solver_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // opcode, row, column, value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // index, solution, status
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata
);
    import bts_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_SIZE);
    localparam int NW = IW + 1;
    localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] QMAX = ACC_W'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] QMIN = -ACC_W'(64'sh80000000);

    logic [DATA_W-1:0] mat_mem [MAX_SIZE*MAX_SIZE];
    logic [DATA_W-1:0] rhs_mem [MAX_SIZE];
    logic [DATA_W-1:0] sol_mem [MAX_SIZE];

    opcode_t in_op;
    logic [3:0] in_row, in_col;
    logic [DATA_W-1:0] in_val;
    assign in_op = opcode_t'(s_axis_tdata[1:0]);
    assign in_row = s_axis_tdata[5:2];
    assign in_col = s_axis_tdata[9:6];
    assign in_val = s_axis_tdata[41:10];

    logic dir_reg;
    logic [4:0] size_reg;
    logic [3:0] band_reg;

    state_t state_reg, state_next;
    logic [NW-1:0] step_reg, step_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic sat_reg, sat_next;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rhs_rd_reg;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [1:0] st_reg, st_next;
    logic [IW-1:0] oidx_reg;
    logic olast_reg;
    logic ovalid_reg;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] j_calc;
    logic in_fire, out_fire;
    logic div_start;
    div_ctl_t div_ctl;
    logic signed [ACC_W-1:0] quo;
    logic empty_range;
    logic [NW-1:0] lo_calc, hi_calc;
    logic [IW+IW-1:0] rd_addr;
    logic rd_en;
    logic signed [ACC_W:0] diff;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        if (size_reg == 5'd0) n_eff = NW'(1);
        else if ({1'b0, size_reg} > 6'(MAX_SIZE)) n_eff = NW'(MAX_SIZE);
        else n_eff = NW'(size_reg);
    end

    assign j_calc = dir_reg ? n_eff - NW'(1) - step_reg : step_reg;

    // row bounds for the current step
    always_comb begin
        if (!dir_reg) begin
            lo_calc = (step_reg > NW'(band_reg)) ? step_reg - NW'(band_reg) : '0;
            hi_calc = step_reg - NW'(1);
            empty_range = (step_reg == '0);
        end else begin
            lo_calc = (n_eff - NW'(1) - step_reg) + NW'(1);
            hi_calc = ((n_eff - NW'(1) - step_reg) + NW'(band_reg) < n_eff - NW'(1)) ?
                      (n_eff - NW'(1) - step_reg) + NW'(band_reg) : n_eff - NW'(1);
            empty_range = (step_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
            size_reg <= 5'd16;
            band_reg <= 4'd15;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_DIRECTION: dir_reg <= cfg_wdata[0];
                CFG_SIZE: size_reg <= cfg_wdata;
                CFG_BAND: band_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // memory port: write on load, read during solve
    assign rd_addr = {j_reg[IW-1:0],
                      (state_reg == S_DIAG) ? j_reg[IW-1:0] : k_reg[IW-1:0]};
    always_ff @(posedge aclk) begin
        if (in_fire && in_op == OP_MATRIX && {1'b0, in_row} < 5'(MAX_SIZE)
            && {1'b0, in_col} < 5'(MAX_SIZE))
            mat_mem[{in_row[IW-1:0], in_col[IW-1:0]}] <= in_val;
        else if (rd_en)
            rd_reg <= mat_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_op == OP_RHS && {1'b0, in_row} < 5'(MAX_SIZE))
            rhs_mem[in_row[IW-1:0]] <= in_val;
        rhs_rd_reg <= rhs_mem[j_calc[IW-1:0]];
        if (state_reg == S_FIN)
            sol_mem[j_reg[IW-1:0]] <= res_next;
    end

    assign rd_en = (state_reg == S_RD) || (state_reg == S_DIAG);
    assign diff = {acc_reg[ACC_W-1], acc_reg} - {prod_reg[ACC_W-1], prod_reg};

    bts_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(acc_reg), .divisor(rd_reg), .ctl(div_ctl), .quotient(quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_fire && in_op == OP_SOLVE) state_next = S_ROW;
            S_ROW:     state_next = (empty_range || k_next > hi_next) ? S_DIAG : S_RD;
            S_RD:      state_next = S_MUL;
            S_MUL:     state_next = S_MAC;
            S_MAC:     state_next = (k_reg == hi_reg) ? S_DIAG : S_RD;
            S_DIAG:    state_next = S_DIV;
            S_DIV:     state_next = ovalid_reg ? S_DIV : S_DIVWAIT;
            S_DIVWAIT: if (div_ctl.done) state_next = S_FIN;
            S_FIN:     state_next = S_OUT;
            S_OUT:     state_next = (step_reg == '0) ? S_IDLE : S_ROW;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        j_next = j_reg;
        k_next = k_reg;
        hi_next = hi_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        res_next = res_reg;
        st_next = st_reg;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE: step_next = '0;
            S_ROW: begin
                j_next = j_calc;
                k_next = lo_calc;
                hi_next = hi_calc;
                acc_next = ACC_W'($signed(rhs_rd_reg)) <<< FRAC_BITS;
                sat_next = 1'b0;
            end
            S_MAC: begin
                if (diff > $signed({1'b0, AMAX})) begin
                    acc_next = AMAX;
                    sat_next = 1'b1;
                end else if (diff < -$signed({1'b0, AMAX})) begin
                    acc_next = -AMAX;
                    sat_next = 1'b1;
                end else begin
                    acc_next = diff[ACC_W-1:0];
                end
                k_next = k_reg + NW'(1);
            end
            S_DIAG: k_next = j_reg;
            S_DIV: div_start = !ovalid_reg;
            S_FIN: begin
                if (rd_reg == '0) begin
                    res_next = '0;
                    st_next = ST_ZERO;
                end else if (quo > QMAX) begin
                    res_next = QMAX[DATA_W-1:0];
                    st_next = ST_SAT;
                end else if (quo < QMIN) begin
                    res_next = QMIN[DATA_W-1:0];
                    st_next = ST_SAT;
                end else begin
                    res_next = quo[DATA_W-1:0];
                    st_next = sat_reg ? ST_SAT : ST_OK;
                end
                step_next = (step_reg + NW'(1) == n_eff) ? '0 : step_reg + NW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next;
        k_reg <= k_next;
        hi_reg <= hi_next;
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        res_reg <= res_next;
        st_reg <= st_next;
        x_reg <= sol_mem[k_reg[IW-1:0]];
        prod_reg <= $signed(rd_reg) * x_reg;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg <= '0;
            olast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (state_reg == S_FIN) begin
                ovalid_reg <= 1'b1;
                oidx_reg <= j_reg[IW-1:0];
                olast_reg <= (step_next == '0);
            end else if (out_fire) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast = olast_reg;
    assign m_axis_tdata = {2'b00, st_reg, res_reg, 4'(oidx_reg)};

    `ASSERT_IMPL(a_ready_idle, aclk, aresetn,
        (state_reg != S_IDLE) |-> !s_axis_tready)
    `ASSERT_NEXT(a_fin_valid, aclk, aresetn, state_reg == S_FIN, m_axis_tvalid)
    `ASSERT_IMPL(a_div_busy, aclk, aresetn,
        (state_reg == S_DIVWAIT && !div_ctl.done) |-> div_ctl.busy || $past(div_ctl.start))
endmodule

@@ design/bts_divider.sv @@
// iterative signed 64 by 32 divider, one quotient bit a cycle, truncating
module bts_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [bts_pkg::ACC_W-1:0]  dividend,
    input  logic signed [bts_pkg::DATA_W-1:0] divisor,
    output bts_pkg::div_ctl_t              ctl,
    output logic signed [bts_pkg::ACC_W-1:0]  quotient
);
    import bts_pkg::*;

    logic [ACC_W-1:0] num_reg, num_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [ACC_W:0] trial;
    logic [ACC_W-1:0] shifted;

    always_comb begin
        shifted = {rem_reg[ACC_W-2:0], num_reg[ACC_W-1]};
        trial = {1'b0, shifted} - {{(ACC_W-DATA_W+1){1'b0}}, den_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            den_next = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
            neg_next = dividend[ACC_W-1] ^ divisor[DATA_W-1];
            rem_next = '0;
            cnt_next = 7'(ACC_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[ACC_W]) begin
                rem_next = trial[ACC_W-1:0];
                num_next = {num_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                num_next = {num_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = neg_reg ? ACC_W'(-num_reg) : ACC_W'(num_reg);
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
endmodule
